### src/crs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crs_pkg: shared constants for the compressor relay sequencer
// Phase codes, field widths, delay reset value and elapsed counter limits.
// ----------------------------------------------------------------------------
package crs_pkg;

	// field widths
	localparam int PHASE_W   = 3;
	localparam int DELAY_W   = 16;
	localparam int ELAPSED_W = 17;

	// phase / target codes
	localparam logic [PHASE_W-1:0] PH_STOPPED    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_VFD_START  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_COMP_START = 3'd2;
	localparam logic [PHASE_W-1:0] PH_RUNNING    = 3'd3;
	localparam logic [PHASE_W-1:0] PH_COMP_STOP  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_VFD_STOP   = 3'd5;

	// request kinds
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	// stage delay after reset, in ticks
	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1000;

	// elapsed counter saturates here
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

endpackage
`default_nettype wire

### src/compressor_relay_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compressor_relay_sequencer: start/stop relay sequencing for a VFD and compressor
// Steps drive, enable and start relays in order on ticks, reverse on shut-down.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | beat contents
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | req_type, new_target
//  out     | out_valid / out_ready| phase, goal, drive_relay, enable_relay,
//          |                      | start_relay, report
//  cfg     | cfg_we (no wait)     | cfg_wdata -> stage_delay
//
//  One beat per clock sustained while out_ready is high; a beat passes the input
//  register, then the sequencer state / result register. The update is one compare
//  on the 17-bit elapsed counter plus a small phase case.
//  Reset puts the sequencer in stopped, goal stopped, relays off, delay 1000.
//  With out_ready low the result holds, the input register takes one more beat,
//  then in_ready drops.
//
module compressor_relay_sequencer (
	input  wire                            clk,
	input  wire                            arst_n,
	// input channel
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire                            req_type,
	input  wire  [crs_pkg::PHASE_W-1:0]    new_target,
	// result channel
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [crs_pkg::PHASE_W-1:0]    phase,
	output logic [crs_pkg::PHASE_W-1:0]    goal,
	output logic                           drive_relay,
	output logic                           enable_relay,
	output logic                           start_relay,
	output logic                           report,
	// configuration
	input  wire                            cfg_we,
	input  wire  [crs_pkg::DELAY_W-1:0]    cfg_wdata
);

	// input stage
	logic                          vld_s1;
	logic                          req_s1;
	logic [crs_pkg::PHASE_W-1:0]   tgt_s1;

	// sequencer state, doubles as the result register
	logic [crs_pkg::PHASE_W-1:0]   phase_q;
	logic [crs_pkg::PHASE_W-1:0]   goal_q;
	logic [crs_pkg::ELAPSED_W-1:0] elapsed_q;
	logic                          drive_q;
	logic                          enable_q;
	logic                          start_q;
	logic                          report_s2;
	logic                          vld_s2;
	logic [crs_pkg::DELAY_W-1:0]   delay_q;

	// next-state values
	logic [crs_pkg::PHASE_W-1:0]   phase_d;
	logic [crs_pkg::PHASE_W-1:0]   goal_d;
	logic [crs_pkg::ELAPSED_W-1:0] elapsed_d;
	logic [crs_pkg::ELAPSED_W-1:0] elapsed_inc;
	logic                          drive_d;
	logic                          enable_d;
	logic                          start_d;
	logic                          report_d;
	logic                          due;
	logic                          go_run;
	logic                          go_stop;
	logic                          adv_s1;

	// flow control: s1 moves on when the result slot is free or being taken
	assign adv_s1   = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= req_type;
			tgt_s1 <= new_target;
		end
	end

	// stage delay register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= crs_pkg::DELAY_RESET;
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	// tick counting and stage qualifiers
	assign elapsed_inc = (elapsed_q == crs_pkg::ELAPSED_MAX) ? elapsed_q
	                                                         : elapsed_q + 1'b1;
	assign due     = elapsed_inc > {1'b0, delay_q};
	assign go_run  = goal_q == crs_pkg::PH_RUNNING;
	assign go_stop = goal_q == crs_pkg::PH_STOPPED;

	// sequencer update for the beat in s1
	always_comb begin
		phase_d   = phase_q;
		goal_d    = goal_q;
		elapsed_d = elapsed_q;
		drive_d   = drive_q;
		enable_d  = enable_q;
		start_d   = start_q;
		report_d  = 1'b0;
		if (req_s1 == crs_pkg::REQ_SET) begin
			// out-of-range targets are dropped
			if (tgt_s1 <= crs_pkg::PH_VFD_STOP) begin
				goal_d   = tgt_s1;
				report_d = 1'b1;
			end
		end else begin
			elapsed_d = elapsed_inc;
			case (phase_q)
				crs_pkg::PH_STOPPED: begin
					if (go_run) begin
						drive_d   = 1'b1;
						phase_d   = crs_pkg::PH_VFD_START;
						elapsed_d = '0;
					end
				end
				crs_pkg::PH_VFD_START: begin
					if (go_run && due) begin
						enable_d  = 1'b1;
						phase_d   = crs_pkg::PH_COMP_START;
						elapsed_d = '0;
					end
				end
				crs_pkg::PH_COMP_START: begin
					if (go_run && due) begin
						start_d   = 1'b1;
						phase_d   = crs_pkg::PH_RUNNING;
						elapsed_d = '0;
					end
				end
				crs_pkg::PH_RUNNING: begin
					// start relay is only pulsed through one tick of running
					start_d = 1'b0;
					if (go_stop) begin
						enable_d  = 1'b0;
						phase_d   = crs_pkg::PH_COMP_STOP;
						elapsed_d = '0;
					end
				end
				crs_pkg::PH_COMP_STOP: begin
					if (go_stop && due) begin
						drive_d   = 1'b0;
						phase_d   = crs_pkg::PH_VFD_STOP;
						elapsed_d = '0;
					end
				end
				crs_pkg::PH_VFD_STOP: begin
					// counter keeps running into stopped
					if (go_stop && due) begin
						phase_d = crs_pkg::PH_STOPPED;
					end
				end
				default: begin
					phase_d = crs_pkg::PH_STOPPED;
				end
			endcase
			report_d = phase_d != phase_q;
		end
	end

	// state / result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= crs_pkg::PH_STOPPED;
			goal_q    <= crs_pkg::PH_STOPPED;
			elapsed_q <= '0;
			drive_q   <= 1'b0;
			enable_q  <= 1'b0;
			start_q   <= 1'b0;
			report_s2 <= 1'b0;
			vld_s2    <= 1'b0;
		end else begin
			if (adv_s1) begin
				phase_q   <= phase_d;
				goal_q    <= goal_d;
				elapsed_q <= elapsed_d;
				drive_q   <= drive_d;
				enable_q  <= enable_d;
				start_q   <= start_d;
				report_s2 <= report_d;
				vld_s2    <= 1'b1;
			end else if (out_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	assign out_valid    = vld_s2;
	assign phase        = phase_q;
	assign goal         = goal_q;
	assign drive_relay  = drive_q;
	assign enable_relay = enable_q;
	assign start_relay  = start_q;
	assign report       = report_s2;

	// drive relay is on exactly between vfd starting and comp stopping
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_q == (phase_q == crs_pkg::PH_VFD_START || phase_q == crs_pkg::PH_COMP_START ||
		            phase_q == crs_pkg::PH_RUNNING || phase_q == crs_pkg::PH_COMP_STOP))
	else $error("drive relay out of step with phase");

	// enable relay only in comp starting or running; start relay only in running
	assert property (@(posedge clk) disable iff (!arst_n)
		(enable_q == (phase_q == crs_pkg::PH_COMP_START || phase_q == crs_pkg::PH_RUNNING)) &&
		(!start_q || phase_q == crs_pkg::PH_RUNNING))
	else $error("enable or start relay out of step with phase");

	// a stalled result keeps the sequencer state frozen
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !out_ready |=> $stable(phase_q) && $stable(goal_q) && $stable(elapsed_q))
	else $error("sequencer state moved under a stalled result");

	// entering any phase but stopped restarts the counter
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && phase_d != phase_q && phase_d != crs_pkg::PH_STOPPED |=> elapsed_q == '0)
	else $error("elapsed counter not restarted on phase advance");

endmodule
`default_nettype wire
